// ===== src/jaha_pkg.sv =====
// Package for the journal append head allocator.
// Holds widths, operation and status codes, and default parameter values.
// No dependencies.
package jaha_pkg;

    localparam int OP_W      = 2;
    localparam int TYPE_W    = 8;
    localparam int LEN_W     = 16;
    localparam int ADDR_W    = 24;
    localparam int STATUS_W  = 2;
    localparam int SEQ_W     = 32;
    localparam int PSIZE_W   = 13;
    localparam int SECTOR_W  = 12;
    localparam int TOTAL_W   = LEN_W + 1;
    localparam int EXT_W     = 30;

    localparam int DEF_SECTOR_BYTES = 4096;
    localparam int DEF_DATA_SECTORS = 255;
    localparam int DEF_MAX_PAYLOAD  = 4096;

    localparam logic [TOTAL_W-1:0] HDR_BYTES  = TOTAL_W'(24);
    localparam logic [TOTAL_W-1:0] ALIGN_MASK = TOTAL_W'(3);
    localparam logic [ADDR_W-1:0]  BASE_RESET = ADDR_W'(4096);

    localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
    localparam logic [OP_W-1:0] OP_MOUNT  = 2'd1;
    localparam logic [OP_W-1:0] OP_FORMAT = 2'd2;
    localparam logic [OP_W-1:0] OP_FAIL   = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_READY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_TOO_LONG  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_HINT  = 2'd3;

    typedef logic [EXT_W-1:0] ext_t;

endpackage

// ===== src/jaha_req_if.sv =====
// Request channel of the journal append head allocator.
// Depends on jaha_pkg for field widths.
interface jaha_req_if;
    logic                          valid;
    logic                          ready;
    logic [jaha_pkg::OP_W-1:0]     operation;
    logic [jaha_pkg::TYPE_W-1:0]   rec_type;
    logic [jaha_pkg::LEN_W-1:0]    payload_len;
    logic [jaha_pkg::ADDR_W-1:0]   hint_addr;

    modport source (output valid, output operation, output rec_type,
                    output payload_len, output hint_addr, input ready);
    modport sink   (input valid, input operation, input rec_type,
                    input payload_len, input hint_addr, output ready);
endinterface

// ===== src/jaha_rsp_if.sv =====
// Result channel of the journal append head allocator.
// Depends on jaha_pkg for field widths.
interface jaha_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [jaha_pkg::STATUS_W-1:0]  status;
    logic                           erase_first;
    logic [jaha_pkg::ADDR_W-1:0]    record_addr;
    logic [jaha_pkg::SEQ_W-1:0]     record_seq;
    logic [jaha_pkg::TYPE_W-1:0]    record_type_out;
    logic [jaha_pkg::PSIZE_W-1:0]   padded_size;
    logic [jaha_pkg::ADDR_W-1:0]    next_head;
    logic                           store_ready;

    modport source (output valid, output status, output erase_first, output record_addr,
                    output record_seq, output record_type_out, output padded_size,
                    output next_head, output store_ready, input ready);
    modport sink   (input valid, input status, input erase_first, input record_addr,
                    input record_seq, input record_type_out, input padded_size,
                    input next_head, input store_ready, output ready);
endinterface

// ===== src/jaha_cfg_if.sv =====
// Configuration write channel carrying the window base address.
// Depends on jaha_pkg for the data width.
interface jaha_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [jaha_pkg::ADDR_W-1:0]  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== src/journal_append_head_allocator.sv =====
// Journal append head allocator: top level.
// Depends on jaha_pkg, jaha_req_if, jaha_rsp_if and jaha_cfg_if.
//
// Usage:
//   req carries one operation per transaction: append, mount at hint,
//   format done or flash failure. rsp returns exactly one result per
//   request, in order: status, record placement, sequence, next head and
//   the store-ready flag. cfg writes the window base address; write it only
//   while no request is in flight. cfg is always ready.
// Registers: an accepted request is held in the input register, and its
//   result is loaded into the result register, which drives rsp.
// Throughput: one request per cycle while rsp does not stall; the head,
//   sector and sequence registers update in the same cycle the result
//   register loads, so the next request sees them at once.
// Reset: the store is not ready, head, sector and sequence are zero and
//   the window base is 4096. Appends are rejected until a format or mount.
// Stall: when rsp is not taken the result register holds, the input
//   register holds one more request, and req.ready drops only then.
module journal_append_head_allocator #(
    parameter int SECTOR_BYTES = jaha_pkg::DEF_SECTOR_BYTES,
    parameter int DATA_SECTORS = jaha_pkg::DEF_DATA_SECTORS,
    parameter int MAX_PAYLOAD  = jaha_pkg::DEF_MAX_PAYLOAD
) (
    input  logic        clk,
    input  logic        rst_n,
    jaha_req_if.sink    req,
    jaha_rsp_if.source  rsp,
    jaha_cfg_if.sink    cfg
);

    localparam int SECTOR_SHIFT = $clog2(SECTOR_BYTES);
    localparam jaha_pkg::ext_t WINDOW_BYTES =
        jaha_pkg::ext_t'(DATA_SECTORS) << SECTOR_SHIFT;
    localparam logic [jaha_pkg::SECTOR_W-1:0] LAST_SECTOR =
        jaha_pkg::SECTOR_W'(DATA_SECTORS);
    localparam logic [jaha_pkg::TOTAL_W-1:0] MAX_LEN =
        jaha_pkg::TOTAL_W'(MAX_PAYLOAD);

    logic [jaha_pkg::ADDR_W-1:0]   window_base_reg;

    logic                          in_valid_reg;
    logic [jaha_pkg::OP_W-1:0]     in_op_reg;
    logic [jaha_pkg::TYPE_W-1:0]   in_type_reg;
    logic [jaha_pkg::LEN_W-1:0]    in_len_reg;
    logic [jaha_pkg::ADDR_W-1:0]   in_hint_reg;

    logic                          ready_flag_reg;
    logic                          ready_flag_next;
    logic [jaha_pkg::ADDR_W-1:0]   head_addr_reg;
    logic [jaha_pkg::ADDR_W-1:0]   head_addr_next;
    logic [jaha_pkg::SECTOR_W-1:0] current_sector_reg;
    logic [jaha_pkg::SECTOR_W-1:0] current_sector_next;
    logic [jaha_pkg::SEQ_W-1:0]    last_seq_reg;
    logic [jaha_pkg::SEQ_W-1:0]    last_seq_next;

    logic                          rsp_valid_reg;
    logic [jaha_pkg::STATUS_W-1:0] status_reg;
    logic [jaha_pkg::STATUS_W-1:0] status_next;
    logic                          erase_reg;
    logic                          erase_next;
    logic [jaha_pkg::ADDR_W-1:0]   raddr_reg;
    logic [jaha_pkg::ADDR_W-1:0]   raddr_next;
    logic [jaha_pkg::SEQ_W-1:0]    rseq_reg;
    logic [jaha_pkg::SEQ_W-1:0]    rseq_next;
    logic [jaha_pkg::TYPE_W-1:0]   rtype_reg;
    logic [jaha_pkg::TYPE_W-1:0]   rtype_next;
    logic [jaha_pkg::PSIZE_W-1:0]  psize_reg;
    logic [jaha_pkg::PSIZE_W-1:0]  psize_next;

    logic                          advance;
    logic                          load_rsp;
    logic                          accept;

    logic [jaha_pkg::TOTAL_W-1:0]  total;
    jaha_pkg::ext_t                sec_end;
    jaha_pkg::ext_t                head_sum;
    jaha_pkg::ext_t                window_end;
    jaha_pkg::ext_t                hint_off;
    logic [jaha_pkg::SECTOR_W-1:0] sector_inc;
    logic [jaha_pkg::SECTOR_W-1:0] sector_wrap;
    logic [jaha_pkg::ADDR_W-1:0]   sector_start;
    logic [jaha_pkg::ADDR_W-1:0]   place_addr;

    assign advance   = !rsp_valid_reg || rsp.ready;
    assign load_rsp  = in_valid_reg && advance;
    assign req.ready = !in_valid_reg || advance;
    assign accept    = req.valid && req.ready;
    assign cfg.ready = 1'b1;

    always_comb
    begin
        total = ((jaha_pkg::TOTAL_W'(in_len_reg) + jaha_pkg::ALIGN_MASK)
                 & ~jaha_pkg::ALIGN_MASK) + jaha_pkg::HDR_BYTES;
        sec_end = jaha_pkg::ext_t'(window_base_reg)
                  + ((jaha_pkg::ext_t'(current_sector_reg) + jaha_pkg::ext_t'(1))
                     << SECTOR_SHIFT);
        head_sum = jaha_pkg::ext_t'(head_addr_reg) + jaha_pkg::ext_t'(total);
        sector_inc = current_sector_reg + jaha_pkg::SECTOR_W'(1);
        sector_wrap = (sector_inc >= LAST_SECTOR) ? '0 : sector_inc;
        sector_start = jaha_pkg::ADDR_W'(jaha_pkg::ext_t'(window_base_reg)
                       + (jaha_pkg::ext_t'(sector_wrap) << SECTOR_SHIFT));
        window_end = jaha_pkg::ext_t'(window_base_reg) + WINDOW_BYTES;
        hint_off = jaha_pkg::ext_t'(in_hint_reg - window_base_reg);
        place_addr = (head_sum > sec_end) ? sector_start : head_addr_reg;

        ready_flag_next     = ready_flag_reg;
        head_addr_next      = head_addr_reg;
        current_sector_next = current_sector_reg;
        last_seq_next       = last_seq_reg;
        status_next         = jaha_pkg::ST_OK;
        erase_next          = 1'b0;
        raddr_next          = '0;
        rseq_next           = '0;
        rtype_next          = '0;
        psize_next          = '0;

        case (in_op_reg)
            jaha_pkg::OP_APPEND:
            begin
                if (!ready_flag_reg)
                begin
                    status_next = jaha_pkg::ST_NOT_READY;
                end
                else if (jaha_pkg::TOTAL_W'(in_len_reg) > MAX_LEN)
                begin
                    status_next = jaha_pkg::ST_TOO_LONG;
                end
                else
                begin
                    if (head_sum > sec_end)
                    begin
                        current_sector_next = sector_wrap;
                        erase_next          = 1'b1;
                    end
                    last_seq_next  = last_seq_reg + jaha_pkg::SEQ_W'(1);
                    rseq_next      = last_seq_next;
                    raddr_next     = place_addr;
                    rtype_next     = in_type_reg;
                    psize_next     = total[jaha_pkg::PSIZE_W-1:0];
                    head_addr_next = place_addr + jaha_pkg::ADDR_W'(total);
                end
            end
            jaha_pkg::OP_MOUNT:
            begin
                if (in_hint_reg < window_base_reg
                    || jaha_pkg::ext_t'(in_hint_reg) >= window_end)
                begin
                    status_next = jaha_pkg::ST_BAD_HINT;
                end
                else
                begin
                    head_addr_next      = in_hint_reg;
                    current_sector_next =
                        jaha_pkg::SECTOR_W'(hint_off >> SECTOR_SHIFT);
                    last_seq_next       = '0;
                    ready_flag_next     = 1'b1;
                end
            end
            jaha_pkg::OP_FORMAT:
            begin
                head_addr_next      = window_base_reg;
                current_sector_next = '0;
                last_seq_next       = '0;
                ready_flag_next     = 1'b1;
            end
            default:
            begin
                ready_flag_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_base_reg    <= jaha_pkg::BASE_RESET;
            in_valid_reg       <= 1'b0;
            rsp_valid_reg      <= 1'b0;
            ready_flag_reg     <= 1'b0;
            head_addr_reg      <= '0;
            current_sector_reg <= '0;
            last_seq_reg       <= '0;
        end
        else
        begin
            if (cfg.valid)
            begin
                window_base_reg <= cfg.data;
            end
            if (accept)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (load_rsp)
            begin
                rsp_valid_reg      <= 1'b1;
                ready_flag_reg     <= ready_flag_next;
                head_addr_reg      <= head_addr_next;
                current_sector_reg <= current_sector_next;
                last_seq_reg       <= last_seq_next;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_op_reg   <= req.operation;
            in_type_reg <= req.rec_type;
            in_len_reg  <= req.payload_len;
            in_hint_reg <= req.hint_addr;
        end
        if (load_rsp)
        begin
            status_reg <= status_next;
            erase_reg  <= erase_next;
            raddr_reg  <= raddr_next;
            rseq_reg   <= rseq_next;
            rtype_reg  <= rtype_next;
            psize_reg  <= psize_next;
        end
    end

    assign rsp.valid           = rsp_valid_reg;
    assign rsp.status          = status_reg;
    assign rsp.erase_first     = erase_reg;
    assign rsp.record_addr     = raddr_reg;
    assign rsp.record_seq      = rseq_reg;
    assign rsp.record_type_out = rtype_reg;
    assign rsp.padded_size     = psize_reg;
    assign rsp.next_head       = head_addr_reg;
    assign rsp.store_ready     = ready_flag_reg;

`ifndef SYNTHESIS
    a_reject_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.status != jaha_pkg::ST_OK |-> !rsp.erase_first
            && rsp.record_seq == '0 && rsp.padded_size == '0)
        else $error("rejected result carries record fields");

    a_erase_ready: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.erase_first |-> rsp.store_ready
            && rsp.status == jaha_pkg::ST_OK)
        else $error("erase request without a ready store");

    a_hold_pending: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_op_reg))
        else $error("pending request lost under stall");
`endif

endmodule

// ===== dv/journal_append_head_allocator_test.sv =====
`timescale 1ns / 100ps
// Testbench for journal_append_head_allocator: predicts each record placement in a
// behavioral copy of the head, sector and sequence state and checks every result.
// Depends on jaha_pkg, jaha_req_if, jaha_rsp_if, jaha_cfg_if and the block itself.
module journal_append_head_allocator_test;

    localparam int SECTOR_BYTES  = jaha_pkg::DEF_SECTOR_BYTES;
    localparam int DATA_SECTORS  = jaha_pkg::DEF_DATA_SECTORS;
    localparam int MAX_PAYLOAD   = jaha_pkg::DEF_MAX_PAYLOAD;
    localparam int QUIET_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 4;
    localparam int HOLD_SPAN     = 60;

    typedef struct packed {
        logic [jaha_pkg::STATUS_W-1:0] status;
        logic                          erase_first;
        logic [jaha_pkg::ADDR_W-1:0]   record_addr;
        logic [jaha_pkg::SEQ_W-1:0]    record_seq;
        logic [jaha_pkg::TYPE_W-1:0]   record_type;
        logic [jaha_pkg::PSIZE_W-1:0]  padded_size;
        logic [jaha_pkg::ADDR_W-1:0]   next_head;
        logic                          store_ready;
    } placement_t;

    logic clk = 1'b0;
    logic rst_n;

    jaha_req_if req ();
    jaha_rsp_if rsp ();
    jaha_cfg_if cfg ();

    journal_append_head_allocator #(
        .SECTOR_BYTES (SECTOR_BYTES),
        .DATA_SECTORS (DATA_SECTORS),
        .MAX_PAYLOAD  (MAX_PAYLOAD)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cfg   (cfg)
    );

    always #6 clk = ~clk;

    logic [jaha_pkg::ADDR_W-1:0]   window_base = jaha_pkg::BASE_RESET;
    logic                          store_on    = 1'b0;
    logic [jaha_pkg::ADDR_W-1:0]   head_ptr    = '0;
    logic [jaha_pkg::SECTOR_W-1:0] sector_idx  = '0;
    logic [jaha_pkg::SEQ_W-1:0]    seq_count   = '0;

    placement_t pending_placements [$];

    bit sender_gaps = 1'b1;
    bit rsp_stalls  = 1'b1;
    int hold_cycles = 0;
    int mismatches  = 0;
    int quiet       = 0;
    int requests    = 0;
    int placed      = 0;
    int erased      = 0;
    int rejected    = 0;
    int mounted     = 0;
    int bases_used  = 0;

    function automatic placement_t plan_placement(logic [jaha_pkg::OP_W-1:0] op,
                                                  logic [jaha_pkg::TYPE_W-1:0] rtype,
                                                  logic [jaha_pkg::LEN_W-1:0] plen,
                                                  logic [jaha_pkg::ADDR_W-1:0] hint);
        placement_t r;
        longint unsigned rec_bytes;
        longint unsigned sec_end;
        longint unsigned win_end;
        r = '0;
        case (op)
            jaha_pkg::OP_APPEND:
            begin
                if (!store_on)
                begin
                    r.status = jaha_pkg::ST_NOT_READY;
                    rejected++;
                end
                else if (plen > MAX_PAYLOAD)
                begin
                    r.status = jaha_pkg::ST_TOO_LONG;
                    rejected++;
                end
                else
                begin
                    rec_bytes = 64'(plen);
                    rec_bytes = 64'd24 + ((rec_bytes + 64'd3) & ~64'd3);
                    sec_end = 64'(window_base)
                              + (64'(sector_idx) + 64'd1) * 64'(SECTOR_BYTES);
                    if (64'(head_ptr) + rec_bytes > sec_end)
                    begin
                        sector_idx = sector_idx + jaha_pkg::SECTOR_W'(1);
                        if (sector_idx >= DATA_SECTORS)
                            sector_idx = '0;
                        head_ptr = jaha_pkg::ADDR_W'(64'(window_base)
                                   + 64'(sector_idx) * 64'(SECTOR_BYTES));
                        r.erase_first = 1'b1;
                        erased++;
                    end
                    seq_count = seq_count + jaha_pkg::SEQ_W'(1);
                    r.record_seq  = seq_count;
                    r.record_addr = head_ptr;
                    r.record_type = rtype;
                    r.padded_size = jaha_pkg::PSIZE_W'(rec_bytes);
                    head_ptr = jaha_pkg::ADDR_W'(64'(head_ptr) + rec_bytes);
                    placed++;
                end
            end
            jaha_pkg::OP_MOUNT:
            begin
                win_end = 64'(window_base) + 64'(DATA_SECTORS) * 64'(SECTOR_BYTES);
                if (hint < window_base || 64'(hint) >= win_end)
                begin
                    r.status = jaha_pkg::ST_BAD_HINT;
                end
                else
                begin
                    head_ptr   = hint;
                    sector_idx = jaha_pkg::SECTOR_W'(32'(hint - window_base)
                                                     / 32'(SECTOR_BYTES));
                    seq_count  = '0;
                    store_on   = 1'b1;
                    mounted++;
                end
            end
            jaha_pkg::OP_FORMAT:
            begin
                head_ptr   = window_base;
                sector_idx = '0;
                seq_count  = '0;
                store_on   = 1'b1;
            end
            default:
            begin
                store_on = 1'b0;
            end
        endcase
        r.next_head   = head_ptr;
        r.store_ready = store_on;
        return r;
    endfunction

    function automatic void check_field(string name, logic [jaha_pkg::SEQ_W-1:0] want,
                                        logic [jaha_pkg::SEQ_W-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    task automatic send_request(logic [jaha_pkg::OP_W-1:0] op,
                                logic [jaha_pkg::TYPE_W-1:0] rtype,
                                logic [jaha_pkg::LEN_W-1:0] plen,
                                logic [jaha_pkg::ADDR_W-1:0] hint);
        if (sender_gaps && $urandom_range(0, 4) == 0)
        begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        req.valid       <= 1'b1;
        req.operation   <= op;
        req.rec_type    <= rtype;
        req.payload_len <= plen;
        req.hint_addr   <= hint;
        do @(posedge clk); while (req.ready !== 1'b1);
        pending_placements.push_back(plan_placement(op, rtype, plen, hint));
        requests++;
    endtask

    task automatic settle_results();
        req.valid <= 1'b0;
        while (pending_placements.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_window_base(logic [jaha_pkg::ADDR_W-1:0] value);
        settle_results();
        cfg.valid <= 1'b1;
        cfg.data  <= value;
        do @(posedge clk); while (cfg.ready !== 1'b1);
        cfg.valid <= 1'b0;
        window_base = value;
        bases_used++;
    endtask

    function automatic logic [jaha_pkg::ADDR_W-1:0] window_hint(
        logic [jaha_pkg::SECTOR_W-1:0] sec);
        return jaha_pkg::ADDR_W'(32'(window_base) + 32'(sec) * 32'(SECTOR_BYTES)
                                 + $urandom_range(0, SECTOR_BYTES - 1));
    endfunction

    task automatic run_random_requests(int count);
        int roll;
        int sel;
        logic [jaha_pkg::OP_W-1:0]     op;
        logic [jaha_pkg::TYPE_W-1:0]   rtype;
        logic [jaha_pkg::LEN_W-1:0]    plen;
        logic [jaha_pkg::ADDR_W-1:0]   hint;
        logic [jaha_pkg::SECTOR_W-1:0] sec;
        repeat (count)
        begin
            rtype = jaha_pkg::TYPE_W'($urandom);
            hint  = jaha_pkg::ADDR_W'($urandom);
            sel   = int'($urandom_range(0, 9));
            if (sel < 5)
                plen = jaha_pkg::LEN_W'($urandom_range(0, 256));
            else if (sel < 8)
                plen = jaha_pkg::LEN_W'($urandom_range(0, MAX_PAYLOAD));
            else if (sel == 8)
                plen = jaha_pkg::LEN_W'(MAX_PAYLOAD);
            else
                plen = jaha_pkg::LEN_W'($urandom);
            if ($urandom_range(0, 1) == 0)
                sec = jaha_pkg::SECTOR_W'($urandom_range(DATA_SECTORS - 5, DATA_SECTORS - 1));
            else
                sec = jaha_pkg::SECTOR_W'($urandom_range(0, DATA_SECTORS - 1));
            roll = int'($urandom_range(0, 99));
            if (!store_on && roll < 60)
            begin
                op = (roll < 30) ? jaha_pkg::OP_FORMAT : jaha_pkg::OP_MOUNT;
                hint = window_hint(sec);
            end
            else if (roll < 80)
            begin
                op = jaha_pkg::OP_APPEND;
            end
            else if (roll < 87)
            begin
                op = jaha_pkg::OP_MOUNT;
                hint = window_hint(sec);
            end
            else if (roll < 91)
            begin
                op = jaha_pkg::OP_MOUNT;
            end
            else if (roll < 96)
            begin
                op = jaha_pkg::OP_FORMAT;
            end
            else
            begin
                op = jaha_pkg::OP_FAIL;
            end
            send_request(op, rtype, plen, hint);
        end
    endtask

    task automatic test_directed_cases();
        send_request(jaha_pkg::OP_APPEND, 8'hFF, 16'hFFFF, 24'hFFFFFF);
        send_request(jaha_pkg::OP_FAIL, 8'h00, 16'h0000, 24'h000000);
        send_request(jaha_pkg::OP_MOUNT, 8'h00, 16'h0000,
                     window_base - jaha_pkg::ADDR_W'(1));
        send_request(jaha_pkg::OP_MOUNT, 8'h00, 16'h0000,
                     jaha_pkg::ADDR_W'(32'(window_base) + DATA_SECTORS * SECTOR_BYTES));
        send_request(jaha_pkg::OP_MOUNT, 8'h00, 16'h0000, 24'hFFFFFF);
        send_request(jaha_pkg::OP_FORMAT, 8'h00, 16'h0000, 24'h000000);
        send_request(jaha_pkg::OP_APPEND, 8'h00, 16'h0000, 24'h000000);
        send_request(jaha_pkg::OP_APPEND, 8'hA5, 16'h0001, 24'hAAAAAA);
        send_request(jaha_pkg::OP_APPEND, 8'h5A, jaha_pkg::LEN_W'(MAX_PAYLOAD), 24'h555555);
        send_request(jaha_pkg::OP_APPEND, 8'h3C, jaha_pkg::LEN_W'(MAX_PAYLOAD + 1),
                     24'h000000);
        send_request(jaha_pkg::OP_APPEND, 8'hC3, 16'hFFFF, 24'h000000);
        send_request(jaha_pkg::OP_MOUNT, 8'h00, 16'h0000,
                     jaha_pkg::ADDR_W'(32'(window_base)
                                       + (DATA_SECTORS - 1) * SECTOR_BYTES + 4000));
        send_request(jaha_pkg::OP_APPEND, 8'h11, 16'd100, 24'h000000);
        send_request(jaha_pkg::OP_MOUNT, 8'h00, 16'h0000, window_base);
        send_request(jaha_pkg::OP_MOUNT, 8'h00, 16'h0000,
                     jaha_pkg::ADDR_W'(32'(window_base) + DATA_SECTORS * SECTOR_BYTES - 1));
        send_request(jaha_pkg::OP_APPEND, 8'h22, 16'd4093, 24'h000000);
        send_request(jaha_pkg::OP_APPEND, 8'h33, 16'd7, 24'h000000);
        send_request(jaha_pkg::OP_FAIL, 8'hFF, 16'hFFFF, 24'hFFFFFF);
        send_request(jaha_pkg::OP_APPEND, 8'h44, 16'd8, 24'h000000);
        send_request(jaha_pkg::OP_FORMAT, 8'h00, 16'h0000, 24'h000000);
        settle_results();
    endtask

    task automatic test_result_backpressure();
        send_request(jaha_pkg::OP_FORMAT, 8'h00, 16'h0000, 24'h000000);
        sender_gaps = 1'b0;
        hold_cycles = HOLD_SPAN;
        repeat (40)
            send_request(jaha_pkg::OP_APPEND, jaha_pkg::TYPE_W'($urandom),
                         jaha_pkg::LEN_W'($urandom_range(0, 512)),
                         jaha_pkg::ADDR_W'($urandom));
        sender_gaps = 1'b1;
        settle_results();
        send_request(jaha_pkg::OP_APPEND, jaha_pkg::TYPE_W'($urandom),
                     jaha_pkg::LEN_W'($urandom_range(0, MAX_PAYLOAD)),
                     jaha_pkg::ADDR_W'($urandom));
        settle_results();
    endtask

    task automatic test_window_sweep();
        logic [jaha_pkg::ADDR_W-1:0] bases [4];
        int                          counts [4];
        int                          i;
        bases[0] = '0;                          counts[0] = 230;
        bases[1] = '1;                          counts[1] = 90;
        bases[2] = 24'hFFF000;                  counts[2] = 120;
        bases[3] = jaha_pkg::ADDR_W'($urandom); counts[3] = 230;
        for (i = 0; i < 4; i++)
        begin
            write_window_base(bases[i]);
            run_random_requests(counts[i]);
        end
    endtask

    task automatic test_full_rate();
        settle_results();
        sender_gaps = 1'b0;
        rsp_stalls  = 1'b0;
        write_window_base(jaha_pkg::BASE_RESET);
        send_request(jaha_pkg::OP_FORMAT, 8'h00, 16'h0000, 24'h000000);
        run_random_requests(220);
    endtask

    initial
    begin : result_receiver
        int span;
        rsp.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_cycles > 0)
            begin
                span = hold_cycles;
                hold_cycles = 0;
                rsp.ready <= 1'b0;
                repeat (span) @(posedge clk);
            end
            else if (rsp_stalls && $urandom_range(0, 3) == 0)
            begin
                rsp.ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
            else
            begin
                rsp.ready <= 1'b1;
                span = int'($urandom_range(1, 20));
                while (span > 0 && hold_cycles == 0)
                begin
                    @(posedge clk);
                    span--;
                end
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        placement_t want;
        if (rst_n === 1'b1 && rsp.valid === 1'b1 && rsp.ready === 1'b1)
        begin
            if (pending_placements.size() == 0)
            begin
                $error("result transaction with no request outstanding");
                mismatches++;
            end
            else
            begin
                want = pending_placements.pop_front();
                check_field("status", 32'(want.status), 32'(rsp.status));
                check_field("erase_first", 32'(want.erase_first), 32'(rsp.erase_first));
                check_field("record_addr", 32'(want.record_addr), 32'(rsp.record_addr));
                check_field("record_seq", want.record_seq, rsp.record_seq);
                check_field("record_type_out", 32'(want.record_type),
                            32'(rsp.record_type_out));
                check_field("padded_size", 32'(want.padded_size), 32'(rsp.padded_size));
                check_field("next_head", 32'(want.next_head), 32'(rsp.next_head));
                check_field("store_ready", 32'(want.store_ready), 32'(rsp.store_ready));
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        if ((req.valid === 1'b1 && req.ready === 1'b1) ||
            (rsp.valid === 1'b1 && rsp.ready === 1'b1) ||
            (cfg.valid === 1'b1 && cfg.ready === 1'b1))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT)
        begin
            $display("journal_append_head_allocator verification failed");
            $finish;
        end
    end

    initial
    begin : test_sequence
        rst_n           <= 1'b0;
        req.valid       <= 1'b0;
        req.operation   <= jaha_pkg::OP_APPEND;
        req.rec_type    <= '0;
        req.payload_len <= '0;
        req.hint_addr   <= '0;
        cfg.valid       <= 1'b0;
        cfg.data        <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_result_backpressure();
        test_window_sweep();
        test_full_rate();

        settle_results();
        $display("Covered %0d requests: %0d records placed, %0d sector erases,",
                 requests, placed, erased);
        $display("%0d rejected appends, %0d accepted mounts, %0d window base writes.",
                 rejected, mounted, bases_used);
        if (mismatches == 0)
            $display("journal_append_head_allocator verification clean");
        else
            $display("journal_append_head_allocator verification failed");
        $finish;
    end
endmodule
